// File: rtl/core/mbr_pkg.sv
package mbr_pkg;

  localparam int unsigned BUF_BYTES_DEF = 2048;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned FETCH_BYTES = 5;
  localparam int unsigned MAX_BITS    = 32;

  localparam logic [2:0] KIND_RESTART = 3'd0;
  localparam logic [2:0] KIND_LOAD    = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_PEEK    = 3'd3;
  localparam logic [2:0] KIND_SKIP    = 3'd4;
  localparam logic [2:0] KIND_ALIGN   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DONE
  } mbr_state_t;

endpackage

// File: rtl/core/msb_first_bit_reader_core.sv
// MSB-first bit reader over a byte buffer held in a single-port synchronous RAM of
// BUF_BYTES entries. One transfer in gives one transfer out. A read or peek of 1 to 32
// bits that fits in the buffer fetches five consecutive bytes, one per cycle from the
// single RAM port, before its result is formed; every other item goes straight from
// acceptance to its result. A result waits in the output register; the next item
// is taken meanwhile and finishes only once that register has been read. Bytes that were
// never loaded read back as undefined.
module msb_first_bit_reader_core
  import mbr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // byte_value[7:0], byte_address[18:8], buffer_length[30:19], bit_count[45:31]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // value[31:0], bits_left[46:32], bytes_left[58:47]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // error[0], success[1]
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int unsigned AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned PW = AW + 4;
  localparam int unsigned SW = ((PW > 15) ? PW : 15) + 1;

  mbr_state_t state_r, state_nxt;

  logic [7:0]    mem [BUF_BYTES];
  logic [7:0]    rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  logic [2:0]  kind_r;
  logic [7:0]  bval_r;
  logic [10:0] addr_r;
  logic [11:0] blen_r;
  logic [14:0] cnt_r;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic          err_r, err_nxt;
  logic [31:0]   win_r;
  logic [2:0]    k_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic in_fire, commit, need_fetch;

  logic [SW-1:0] pos_ext, total_ext, in_sum, step_w, sum_w;
  logic          over_w, ok_w, in_range;
  logic [3:0]    align_step;
  logic [31:0]   value_w, mask_w, blen32, clamp32, tot32, addr32, rem32;
  logic [39:0]   win40, shifted;
  logic [5:0]    sh_w;
  logic [PW-1:0] rem_w;
  logic [AW:0]   rd_idx;

  assign in_fire   = in_tvalid && in_tready;
  assign pos_ext   = SW'(pos_r);
  assign total_ext = SW'(total_r);
  assign in_sum    = pos_ext + SW'(in_tdata[45:31]);

  assign need_fetch = ((in_tuser == KIND_READ) || (in_tuser == KIND_PEEK)) &&
                      (in_tdata[45:31] != 15'd0) &&
                      (in_tdata[45:31] <= 15'(MAX_BITS)) &&
                      (in_sum <= total_ext);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = need_fetch ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        if (k_r == 3'(FETCH_BYTES - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_FETCH: rd_en = 1'b1;
      ST_DONE: begin
        commit = !out_valid_r || out_tready;
        wr_en  = commit && (kind_r == KIND_LOAD) && in_range;
      end
      default: ;
    endcase
  end

  assign rd_idx  = pos_r[PW-1:3] + (AW + 1)'(k_r);
  assign rd_addr = rd_idx[AW-1:0];
  assign addr32  = {21'd0, addr_r};
  assign wr_addr = addr32[AW-1:0];
  assign in_range = addr32 < 32'(BUF_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= bval_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    align_step = 4'd8 - {1'b0, pos_r[2:0]};
    step_w     = (kind_r == KIND_ALIGN) ? SW'(align_step) : SW'(cnt_r);
    sum_w      = pos_ext + step_w;
    over_w     = sum_w > total_ext;

    win40   = {win_r, rd_data_r};
    sh_w    = 6'd40 - {3'd0, pos_r[2:0]} - cnt_r[5:0];
    shifted = win40 >> sh_w;
    mask_w  = 32'hFFFF_FFFF >> (6'd32 - cnt_r[5:0]);

    blen32  = {20'd0, blen_r};
    clamp32 = (blen32 > 32'(BUF_BYTES)) ? 32'(BUF_BYTES) : blen32;
    tot32   = clamp32 << 3;

    value_w   = 32'd0;
    ok_w      = 1'b0;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    case (kind_r)
      KIND_RESTART: begin
        total_nxt = tot32[PW-1:0];
        pos_nxt   = '0;
        err_nxt   = 1'b0;
      end
      KIND_READ, KIND_PEEK: begin
        if (cnt_r != 15'd0) begin
          if ((cnt_r > 15'(MAX_BITS)) || over_w) begin
            err_nxt = 1'b1;
          end else begin
            value_w = shifted[31:0] & mask_w;
            if (kind_r == KIND_READ) begin
              pos_nxt = sum_w[PW-1:0];
            end
          end
        end
      end
      KIND_SKIP, KIND_ALIGN: begin
        if ((kind_r == KIND_ALIGN) && (pos_r[2:0] == 3'd0)) begin
          ok_w = 1'b1;
        end else if (over_w) begin
          pos_nxt = total_r;
          err_nxt = 1'b1;
        end else begin
          pos_nxt = sum_w[PW-1:0];
          ok_w    = 1'b1;
        end
      end
      default: ;
    endcase

    rem_w = (pos_nxt >= total_nxt) ? '0 : (total_nxt - pos_nxt);
    rem32 = 32'(rem_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pos_r       <= pos_nxt;
        total_r     <= total_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      bval_r <= in_tdata[7:0];
      addr_r <= in_tdata[18:8];
      blen_r <= in_tdata[30:19];
      cnt_r  <= in_tdata[45:31];
      k_r    <= 3'd0;
    end else if (state_r == ST_FETCH) begin
      k_r <= k_r + 3'd1;
      if (k_r != 3'd0) begin
        win_r <= {win_r[23:0], rd_data_r};
      end
    end
    if (commit) begin
      out_data_r <= {5'd0, rem32[14:3], rem32[14:0], value_w};
      out_user_r <= {ok_w, err_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= total_r)
    else $error("bit position beyond buffer end");

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("RAM read and write in one cycle");

  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (k_r < 3'(FETCH_BYTES)))
    else $error("fetch ran past five bytes");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted transfer not processed");

  a_err_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(err_r) |-> ($past(kind_r) == KIND_RESTART))
    else $error("sticky error cleared without restart");

endmodule

// File: bench/msb_first_bit_reader_core_tb.sv
`timescale 1ns / 1ps

module msb_first_bit_reader_core_tb;
  import mbr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEM_TARGET = 1650;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  bval;
    logic [10:0] addr;
    logic [11:0] blen;
    logic [14:0] cnt;
  } reader_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
    logic        ok;
    logic [14:0] bits_left;
    logic [11:0] bytes_left;
  } reader_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  reader_item_t pending_items[$];
  reader_res_t  expected_results[$];
  reader_item_t offer;

  // predictor state, advanced at each accepted input transfer
  logic [7:0]  pred_mem[0:BUF_BYTES_DEF-1];
  int unsigned pred_pos = 0;
  int unsigned pred_total = 0;
  bit          pred_err = 1'b0;

  // stimulus planning state, advanced as items are queued
  bit          plan_written[0:BUF_BYTES_DEF-1];
  int unsigned plan_pos = 0;
  int unsigned plan_total = 0;
  bit          plan_err = 1'b0;

  int unsigned cycle_cnt = 0;
  int unsigned quiet = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned fails = 0;
  int unsigned results_seen = 0;
  int unsigned error_results = 0;
  int unsigned kind_seen[8];

  wire calm = (cycle_cnt >= 2000) && (cycle_cnt < 4500);

  msb_first_bit_reader_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic void move_cursor(input logic [2:0] kind, input int unsigned blen,
                                      input int unsigned cnt, inout int unsigned pos,
                                      inout int unsigned total, inout bit err,
                                      output bit ok);
    int unsigned step;
    ok = 1'b0;
    case (kind)
      KIND_RESTART: begin
        total = ((blen > BUF_BYTES_DEF) ? BUF_BYTES_DEF : blen) * 8;
        pos = 0;
        err = 1'b0;
      end
      KIND_READ, KIND_PEEK: begin
        if (cnt != 0) begin
          if (cnt > MAX_BITS || pos + cnt > total) err = 1'b1;
          else if (kind == KIND_READ) pos = pos + cnt;
        end
      end
      KIND_SKIP, KIND_ALIGN: begin
        if (kind == KIND_SKIP) step = cnt;
        else step = (pos % 8 != 0) ? 8 - pos % 8 : 0;
        if (pos + step > total) begin
          pos = total;
          err = 1'b1;
        end else begin
          pos = pos + step;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic reader_res_t predict_reader(input reader_item_t it);
    reader_res_t r;
    int unsigned p;
    int unsigned left;
    bit ok;
    r = '0;
    if ((it.kind == KIND_READ || it.kind == KIND_PEEK) && it.cnt != 0 &&
        it.cnt <= MAX_BITS && pred_pos + it.cnt <= pred_total) begin
      for (int unsigned i = 0; i < it.cnt; i++) begin
        p = pred_pos + i;
        r.value = {r.value[30:0], pred_mem[p >> 3][7 - (p % 8)]};
      end
    end
    if (it.kind == KIND_LOAD && it.addr < BUF_BYTES_DEF) pred_mem[it.addr] = it.bval;
    move_cursor(it.kind, it.blen, it.cnt, pred_pos, pred_total, pred_err, ok);
    left = (pred_pos >= pred_total) ? 0 : pred_total - pred_pos;
    r.ok = ok;
    r.err = pred_err;
    r.bits_left = 15'(left);
    r.bytes_left = 12'(left >> 3);
    return r;
  endfunction

  function automatic void plan_item(input reader_item_t it);
    bit ok;
    pending_items.push_back(it);
    if (it.kind == KIND_LOAD) plan_written[it.addr] = 1'b1;
    move_cursor(it.kind, it.blen, it.cnt, plan_pos, plan_total, plan_err, ok);
  endfunction

  // load any byte a legal read would fetch before queuing the read itself
  task automatic queue_item(input logic [2:0] kind, input int unsigned bval,
                            input int unsigned addr, input int unsigned blen,
                            input int unsigned cnt);
    reader_item_t it;
    reader_item_t fill;
    int unsigned first;
    if ((kind == KIND_READ || kind == KIND_PEEK) && cnt != 0 && cnt <= MAX_BITS &&
        plan_pos + cnt <= plan_total) begin
      first = plan_pos >> 3;
      for (int unsigned a = first; a < first + FETCH_BYTES && a < BUF_BYTES_DEF; a++) begin
        if (!plan_written[a]) begin
          fill.kind = KIND_LOAD;
          fill.bval = 8'($urandom);
          fill.addr = 11'(a);
          fill.blen = 12'($urandom);
          fill.cnt = 15'($urandom);
          plan_item(fill);
        end
      end
    end
    it.kind = kind;
    it.bval = 8'(bval);
    it.addr = 11'(addr);
    it.blen = 12'(blen);
    it.cnt = 15'(cnt);
    plan_item(it);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
    fails++;
    if (fails <= 50)
      $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
               $time, results_seen, field, want, seen);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_reader(offer));
        kind_seen[offer.kind]++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          offer = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, offer.cnt, offer.blen, offer.addr, offer.bval};
          in_tuser <= offer.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    reader_res_t got;
    reader_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[31:0];
      got.bits_left = out_tdata[46:32];
      got.bytes_left = out_tdata[58:47];
      got.err = out_tuser[0];
      got.ok = out_tuser[1];
      results_seen++;
      if (got.err === 1'b1) error_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got.value);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) report_mismatch("value", want.value, got.value);
        if (got.err !== want.err) report_mismatch("error", want.err, got.err);
        if (got.ok !== want.ok) report_mismatch("success", want.ok, got.ok);
        if (got.bits_left !== want.bits_left)
          report_mismatch("bits_left", want.bits_left, got.bits_left);
        if (got.bytes_left !== want.bytes_left)
          report_mismatch("bytes_left", want.bytes_left, got.bytes_left);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned left;
    int unsigned cnt;
    logic [2:0] kind;

    for (int i = 0; i < BUF_BYTES_DEF; i++) begin
      pred_mem[i] = '0;
      plan_written[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;

    queue_item(KIND_RESTART, 0, 0, 4095, 0);
    queue_item(KIND_LOAD, 255, 2047, 4095, 32767);
    queue_item(KIND_LOAD, 0, 0, 0, 0);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 0);
    queue_item(KIND_PEEK, $urandom, $urandom, $urandom, 32);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 33);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 32767);
    queue_item(KIND_SKIP, $urandom, $urandom, $urandom, 16383);
    queue_item(KIND_PEEK, $urandom, $urandom, $urandom, 1);
    queue_item(KIND_SKIP, $urandom, $urandom, $urandom, 2);
    queue_item(KIND_RESTART, $urandom, $urandom, 3, $urandom);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 20);
    queue_item(KIND_PEEK, $urandom, $urandom, $urandom, 4);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 5);
    queue_item(KIND_ALIGN, $urandom, $urandom, $urandom, $urandom);
    queue_item(KIND_ALIGN, $urandom, $urandom, $urandom, $urandom);
    queue_item(KIND_SKIP, $urandom, $urandom, $urandom, 0);
    queue_item(3'd6, $urandom, $urandom, $urandom, $urandom);
    queue_item(3'd7, $urandom, $urandom, $urandom, $urandom);
    queue_item(KIND_RESTART, $urandom, $urandom, 0, $urandom);
    queue_item(KIND_READ, $urandom, $urandom, $urandom, 1);
    queue_item(KIND_ALIGN, $urandom, $urandom, $urandom, $urandom);
    queue_item(KIND_SKIP, $urandom, $urandom, $urandom, 32767);

    while (pending_items.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 24);
      else if (r < 90) len = $urandom_range(0, 4095);
      else if (r < 95) len = BUF_BYTES_DEF;
      else len = 0;
      queue_item(KIND_RESTART, $urandom, $urandom, len, $urandom);
      if (len <= 24)
        for (int unsigned a = 0; a < len; a++)
          queue_item(KIND_LOAD, $urandom, a, $urandom, $urandom);
      repeat ($urandom_range(6, 30)) begin
        left = (plan_pos >= plan_total) ? 0 : plan_total - plan_pos;
        r = $urandom_range(0, 99);
        if (r < 30) kind = KIND_READ;
        else if (r < 45) kind = KIND_PEEK;
        else if (r < 62) kind = KIND_SKIP;
        else if (r < 75) kind = KIND_ALIGN;
        else if (r < 85) kind = KIND_LOAD;
        else if (r < 90) kind = 3'($urandom_range(6, 7));
        else kind = KIND_READ;
        r = $urandom_range(0, 99);
        if (kind == KIND_READ || kind == KIND_PEEK) begin
          if (r < 75 && left != 0) cnt = $urandom_range(1, (left < 32) ? left : 32);
          else if (r < 83) cnt = 0;
          else if (r < 91) cnt = $urandom_range(33, 40);
          else cnt = $urandom_range(0, 32767);
        end else if (kind == KIND_SKIP) begin
          if (r < 70) cnt = $urandom_range(0, (left < 20) ? left : 20);
          else if (r < 90) cnt = $urandom_range(0, 40);
          else cnt = $urandom_range(0, 32767);
        end else begin
          cnt = $urandom;
        end
        queue_item(kind, $urandom, $urandom, $urandom, cnt);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d restart, %0d load, %0d read, %0d peek, %0d skip, %0d align, %0d unused",
             kind_seen[KIND_RESTART], kind_seen[KIND_LOAD], kind_seen[KIND_READ],
             kind_seen[KIND_PEEK], kind_seen[KIND_SKIP], kind_seen[KIND_ALIGN],
             kind_seen[6] + kind_seen[7]);
    $display("Checked %0d results, %0d with sticky error set, one %0d-cycle output hold-off",
             results_seen, error_results, HOLD_CYCLES);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
